>>> hdl/spp_pkg.sv
// Shared types, widths and codes for the speed-to-step-period unit.
`default_nettype none

package spp_pkg;

   // Field widths
   localparam int CmdW     = 32;
   localparam int SpeedW   = 31;
   localparam int RateW    = 48;
   localparam int PeriodW  = 32;
   localparam int CompareW = 31;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 48;

   // Configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_RATE_CONSTANT = 2'd0,
      CSR_MAX_SPEED     = 2'd1,
      CSR_MIN_SPEED     = 2'd2,
      CSR_REVERSE_DIR   = 2'd3
   } csr_index_type;

   // What the back end does with a command
   typedef enum logic [1:0] {
      KIND_STOP = 2'd0,   // below minimum: only compare = 0
      KIND_HOLD = 2'd1,   // zero speed: direction written, pulses stopped
      KIND_DIV  = 2'd2    // direction written, period from the divider
   } kind_type;

   // Classified command, as queued between front and back
   typedef struct packed {
      kind_type          kind;
      logic              dir_level;
      logic [SpeedW-1:0] mag;
   } cls_type;

   // Partial state of the restoring divider
   typedef struct packed {
      logic [SpeedW-1:0] rem;
      logic [RateW-1:0]  num;   // dividend bits shift out, quotient bits shift in
   } div_stage_type;

   // One restoring division step: one quotient bit
   function automatic div_stage_type div_step(input div_stage_type cur,
                                              input logic [SpeedW-1:0] divisor);
      logic [SpeedW:0] trial;
      logic [SpeedW:0] diff;
      logic            ge;
      div_stage_type   nxt;
      trial   = {cur.rem, cur.num[RateW-1]};
      diff    = trial - {1'b0, divisor};
      ge      = (trial >= {1'b0, divisor});
      nxt.rem = ge ? diff[SpeedW-1:0] : trial[SpeedW-1:0];
      nxt.num = {cur.num[RateW-2:0], ge};
      return nxt;
   endfunction

endpackage

`default_nettype wire

>>> hdl/spp_ifc.sv
// Channel interfaces: speed command in, timer settings out.
`default_nettype none

interface spp_req_if;
   import spp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [CmdW-1:0] speed_cmd;
   modport source (output valid, output speed_cmd, input ready);
   modport sink   (input valid, input speed_cmd, output ready);
endinterface

interface spp_rsp_if;
   import spp_pkg::*;
   logic                valid;
   logic                ready;
   logic                dir_written;
   logic                dir_level;
   logic                period_written;
   logic [PeriodW-1:0]  period;
   logic [CompareW-1:0] compare;
   modport source (output valid, output dir_written, output dir_level,
                   output period_written, output period, output compare,
                   input ready);
   modport sink   (input valid, input dir_written, input dir_level,
                   input period_written, input period, input compare,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/spp_front.sv
// Front end: takes a speed command, clamps it and classifies it.
`default_nettype none

module spp_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   spp_req_if.sink                         req_chan,
   input  wire logic [spp_pkg::SpeedW-1:0] max_speed,
   input  wire logic [spp_pkg::SpeedW-1:0] min_speed,
   input  wire logic                       reverse_dir,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output spp_pkg::cls_type                out_data
);
   import spp_pkg::*;

   logic                   front_valid_ff;
   logic                   front_valid_in;
   logic signed [CmdW-1:0] cmd_ff;
   logic                   neg;
   logic [CmdW-1:0]        mag_full;
   logic                   over;
   logic                   under;
   logic [SpeedW-1:0]      mag_clamped;

   // Holding register, freed as soon as the item moves into the queue
   assign req_chan.ready = !front_valid_ff || out_ready;
   assign out_valid      = front_valid_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         front_valid_in = 1'b1;
      end else if (out_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= req_chan.speed_cmd;
      end
   end

   // Magnitude; the most negative command gives 2^31
   assign neg      = cmd_ff[CmdW-1];
   assign mag_full = neg ? (~cmd_ff + 1'b1) : cmd_ff;
   assign over     = (mag_full > {1'b0, max_speed});
   assign under    = (mag_full < {1'b0, min_speed});
   // When not over the limit the magnitude fits the speed width
   assign mag_clamped = over ? max_speed : mag_full[SpeedW-1:0];

   // Classify: a clamped command never counts as below minimum
   always_comb begin
      out_data.mag       = mag_clamped;
      out_data.dir_level = reverse_dir;
      if (!over && under) begin
         out_data.kind = KIND_STOP;
      end else if (mag_clamped == '0) begin
         out_data.kind = KIND_HOLD;
      end else begin
         out_data.kind      = KIND_DIV;
         out_data.dir_level = neg ? reverse_dir : !reverse_dir;
      end
   end

endmodule

`default_nettype wire

>>> hdl/spp_queue.sv
// Small FIFO between the classifying front end and the divider back end.
`default_nettype none

module spp_queue #(
   parameter int Depth = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire spp_pkg::cls_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output spp_pkg::cls_type       out_data
);
   import spp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cls_type           mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/spp_back.sv
// Back end: pipelined restoring divider, saturation and result register.
`default_nettype none

module spp_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire spp_pkg::cls_type          in_data,
   input  wire logic [spp_pkg::RateW-1:0] rate_constant,
   spp_rsp_if.source                      rsp_chan
);
   import spp_pkg::*;

   // One quotient bit per stage
   localparam int NumStages = RateW;

   logic              stg_valid_ff [NumStages];
   kind_type          stg_kind_ff  [NumStages];
   logic              stg_dir_ff   [NumStages];
   logic [SpeedW-1:0] stg_div_ff   [NumStages];
   div_stage_type     stg_part_ff  [NumStages];
   div_stage_type     stg_part_in  [NumStages];
   div_stage_type     first_part;

   logic                advance;
   logic                rsp_valid_ff;
   logic                dir_written_ff;
   logic                dir_level_ff;
   logic                period_written_ff;
   logic [PeriodW-1:0]  period_ff;
   logic [CompareW-1:0] compare_ff;

   logic                dir_written_in;
   logic                dir_level_in;
   logic                period_written_in;
   logic [PeriodW-1:0]  period_in;
   logic [CompareW-1:0] compare_in;
   logic [RateW-1:0]    quotient;

   // The whole pipeline moves while the result register is free or taken
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign in_ready = advance;

   // Next partial state of every stage
   always_comb begin
      first_part.rem = '0;
      first_part.num = rate_constant;
      stg_part_in[0] = div_step(first_part, in_data.mag);
      for (int i = 1; i < NumStages; i++) begin
         stg_part_in[i] = div_step(stg_part_ff[i-1], stg_div_ff[i-1]);
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStages; i++) begin
            stg_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         stg_valid_ff[0] <= in_valid;
         for (int i = 1; i < NumStages; i++) begin
            stg_valid_ff[i] <= stg_valid_ff[i-1];
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         stg_kind_ff[0] <= in_data.kind;
         stg_dir_ff[0]  <= in_data.dir_level;
         stg_div_ff[0]  <= in_data.mag;
         stg_part_ff[0] <= stg_part_in[0];
         for (int i = 1; i < NumStages; i++) begin
            stg_kind_ff[i] <= stg_kind_ff[i-1];
            stg_dir_ff[i]  <= stg_dir_ff[i-1];
            stg_div_ff[i]  <= stg_div_ff[i-1];
            stg_part_ff[i] <= stg_part_in[i];
         end
      end
   end

   // Result fields: saturate the quotient to 32 bits
   assign quotient = stg_part_ff[NumStages-1].num;

   always_comb begin
      dir_written_in    = 1'b0;
      dir_level_in      = 1'b0;
      period_written_in = 1'b0;
      period_in         = '0;
      compare_in        = '0;
      unique case (stg_kind_ff[NumStages-1])
         KIND_STOP: begin
         end
         KIND_HOLD: begin
            dir_written_in = 1'b1;
            dir_level_in   = stg_dir_ff[NumStages-1];
         end
         KIND_DIV: begin
            dir_written_in    = 1'b1;
            dir_level_in      = stg_dir_ff[NumStages-1];
            period_written_in = 1'b1;
            period_in         = (quotient[RateW-1:PeriodW] != '0) ? '1
                                                                 : quotient[PeriodW-1:0];
            compare_in        = period_in[PeriodW-1:1];
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stg_valid_ff[NumStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_written_ff    <= dir_written_in;
         dir_level_ff      <= dir_level_in;
         period_written_ff <= period_written_in;
         period_ff         <= period_in;
         compare_ff        <= compare_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.dir_written    = dir_written_ff;
   assign rsp_chan.dir_level      = dir_level_ff;
   assign rsp_chan.period_written = period_written_ff;
   assign rsp_chan.period         = period_ff;
   assign rsp_chan.compare        = compare_ff;

endmodule

`default_nettype wire

>>> hdl/stepper_speed_to_pulse_period_unit.sv
// Stepper speed to step-period unit. Each signed Q16.16 speed command gives
// one result: direction pin update, timer period = rate_constant / |speed|
// (clamped to max_speed, saturated to 32 bits) and compare = period / 2, or
// compare = 0 when the speed is below min_speed or zero. A new command is
// taken every cycle while the queue and the result side do not stall. Each
// command passes through the classifying stage, the queue, the divider,
// which resolves one of its 48 quotient bits per pipeline stage, and the
// result register. Configuration writes take effect at once and are meant
// to be made while no command is in flight.
`default_nettype none

module stepper_speed_to_pulse_period_unit #(
   parameter int QueueDepth = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   spp_req_if.sink                           req_chan,
   spp_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_we,
   input  wire logic [spp_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [spp_pkg::CsrDataW-1:0] csr_wdata
);
   import spp_pkg::*;

   logic [RateW-1:0]  rate_constant_ff;
   logic [SpeedW-1:0] max_speed_ff;
   logic [SpeedW-1:0] min_speed_ff;
   logic              reverse_dir_ff;

   logic    fq_valid;
   logic    fq_ready;
   cls_type fq_data;
   logic    qb_valid;
   logic    qb_ready;
   cls_type qb_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_constant_ff <= '0;
         max_speed_ff     <= '0;
         min_speed_ff     <= '0;
         reverse_dir_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATE_CONSTANT: rate_constant_ff <= csr_wdata[RateW-1:0];
            CSR_MAX_SPEED:     max_speed_ff     <= csr_wdata[SpeedW-1:0];
            CSR_MIN_SPEED:     min_speed_ff     <= csr_wdata[SpeedW-1:0];
            CSR_REVERSE_DIR:   reverse_dir_ff   <= csr_wdata[0];
         endcase
      end
   end

   spp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .max_speed   (max_speed_ff),
      .min_speed   (min_speed_ff),
      .reverse_dir (reverse_dir_ff),
      .out_valid   (fq_valid),
      .out_ready   (fq_ready),
      .out_data    (fq_data)
   );

   spp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   spp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (qb_valid),
      .in_ready      (qb_ready),
      .in_data       (qb_data),
      .rate_constant (rate_constant_ff),
      .rsp_chan      (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hdl/spp_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module spp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_dir_written,
   input wire logic                           rsp_dir_level,
   input wire logic                           rsp_period_written,
   input wire logic [spp_pkg::PeriodW-1:0]    rsp_period,
   input wire logic [spp_pkg::CompareW-1:0]   rsp_compare
);

   // A stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dir_written)
         && $stable(rsp_dir_level) && $stable(rsp_period_written)
         && $stable(rsp_period) && $stable(rsp_compare))
      else $error("result changed while stalled");

   // Below-minimum item writes nothing but a zero compare
   a_stop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dir_written |-> !rsp_dir_level && !rsp_period_written
         && (rsp_period == '0) && (rsp_compare == '0))
      else $error("stop item carries stray fields");

   // A period comes with a direction write and half-period compare
   a_period_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_written |-> rsp_dir_written
         && (rsp_compare == rsp_period[spp_pkg::PeriodW-1:1]))
      else $error("compare is not half the period");

   // No period means pulses stopped
   a_no_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_period_written |-> (rsp_period == '0) && (rsp_compare == '0))
      else $error("stopped item carries a period or compare");

endmodule

bind stepper_speed_to_pulse_period_unit spp_checker u_spp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_dir_written    (rsp_chan.dir_written),
   .rsp_dir_level      (rsp_chan.dir_level),
   .rsp_period_written (rsp_chan.period_written),
   .rsp_period         (rsp_chan.period),
   .rsp_compare        (rsp_chan.compare)
);

`default_nettype wire
